### rtl/rmp_pkg.sv
// Shared types and constants for the regret-matching-plus update block.
package rmp_pkg;

   localparam int REGRET_W = 31;
   localparam int SUM_W    = 48;
   localparam int PROB_W   = 17;
   localparam logic [PROB_W-1:0] ONE_Q16 = 17'd65536;

   typedef struct packed {
      logic signed [31:0] regret_delta;
      logic [16:0]        reach_prob;
   } req_type;

   typedef struct packed {
      logic [3:0]  action_index;
      logic [16:0] current_prob;
      logic [16:0] average_prob;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RSUM,
      ST_UNI,
      ST_UNI_WAIT,
      ST_CDIV,
      ST_CDIV_WAIT,
      ST_MUL,
      ST_MUL_ACC,
      ST_ADIV,
      ST_ADIV_WAIT,
      ST_OUT
   } state_type;

   // Divider request: dividend and divisor, both up to 64 bits.
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

endpackage

### rtl/rmp_divider.sv
// Radix-2 restoring divider: one quotient bit per cycle.
module rmp_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rmp_pkg::div_req_type div_req,
   output rmp_pkg::div_rsp_type div_rsp
);
   import rmp_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[63:0], quo_ff[63]};
      trial   = shifted - {1'b0, den_ff};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Shift in the next dividend bit, subtract when it fits.
         if (!trial[64]) begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

`ifndef NO_ASSERTIONS
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !div_req.start) |=> (cnt_ff == $past(cnt_ff) + 7'd1) || done_ff)
      else $error("divider count skipped");
`endif
endmodule

### rtl/regret_matching_plus_update.sv
// Regret-matching-plus update: input items are taken while the sequencer is idle. The
// item that closes a run of N actions starts it, and the input stalls until it is done.
// The sequencer sums the N regrets, then divides for the uniform value. Each action
// then gets its current probability and strategy sum update, and afterwards each
// action gets its average probability and its result. Each divide uses the shared
// bit-serial divider. A zero regret sum skips the current-probability divides and
// uses the uniform value; a zero total skips the average divides and uses it too.
// Results go out one per action through an output register with stall. While a
// result waits there, the sequencer holds. Regret, strategy sum, strategy and reach
// stores are small register files read at the sequencer index; regret is also read
// at the input slot. num_actions of zero acts as one, above MAX_ACTIONS as
// MAX_ACTIONS; a csr write drops a partial run. Reset loads all-zero regrets and
// sums and uniform strategy.
module regret_matching_plus_update #(
   parameter int MAX_ACTIONS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rmp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rmp_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [4:0]       csr_data
);
   import rmp_pkg::*;

   localparam int IW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
   localparam int CW = $clog2(MAX_ACTIONS + 1);
   localparam logic [PROB_W-1:0] UNI_RST =
      PROB_W'(65536 / ((MAX_ACTIONS < 16) ? MAX_ACTIONS : 16));

   logic [REGRET_W-1:0] regret_ff [MAX_ACTIONS];
   logic [SUM_W-1:0]    ssum_ff   [MAX_ACTIONS];
   logic [PROB_W-1:0]   strat_ff  [MAX_ACTIONS];
   logic [PROB_W-1:0]   reach_ff  [MAX_ACTIONS];

   logic [4:0]    num_ff;
   logic [CW-1:0] count_ff, count_in;
   state_type     state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [35:0]   rsum_ff, rsum_in;   // up to 31 * (2^31-1)
   logic [53:0]   tot_ff, tot_in;     // up to 31 * (2^48-1)
   logic [PROB_W-1:0] uni_ff, uni_in;
   logic [PROB_W-1:0] avg_ff;
   logic [33:0]   prod_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [CW-1:0] n_act;
   logic [CW-1:0] slot;
   logic [IW-1:0] item_idx;
   logic          accept, closes, last_idx;
   logic          out_load;
   logic signed [32:0] nr;
   logic [REGRET_W-1:0] nr_sat;
   logic [PROB_W-1:0]   reach_sat;
   logic [48:0]   ssum_new;

   rmp_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   // Clamp the action count into 1..MAX_ACTIONS.
   always_comb begin
      if (num_ff == 5'd0)
         n_act = CW'(1);
      else if (32'(num_ff) > MAX_ACTIONS)
         n_act = CW'(MAX_ACTIONS);
      else
         n_act = CW'(num_ff);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot      = (count_ff >= n_act) ? n_act - CW'(1) : count_ff;
   assign item_idx  = IW'(slot);
   assign closes    = (slot + CW'(1) >= n_act);
   assign last_idx  = (CW'(idx_ff) + CW'(1) == n_act);

   // Load the output register when it is empty or its item leaves this cycle.
   assign out_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   // Accumulate regret, clamp at zero, saturate at the top.
   always_comb begin
      nr = $signed({2'b00, regret_ff[item_idx]}) + 33'(req_data.regret_delta);
      if (nr < 0)
         nr_sat = '0;
      else if (nr > 33'sh7FFFFFFF)
         nr_sat = '1;
      else
         nr_sat = nr[REGRET_W-1:0];
      reach_sat = (req_data.reach_prob > ONE_Q16) ? ONE_Q16 : req_data.reach_prob;
      ssum_new  = {1'b0, ssum_ff[idx_ff]} + 49'(prod_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (accept && closes) state_in = ST_RSUM;
         ST_RSUM:      if (last_idx) state_in = ST_UNI;
         ST_UNI:       state_in = ST_UNI_WAIT;
         ST_UNI_WAIT:  if (div_rsp.done) state_in = ST_CDIV;
         ST_CDIV:      state_in = (rsum_ff == '0) ? ST_MUL : ST_CDIV_WAIT;
         ST_CDIV_WAIT: if (div_rsp.done) state_in = ST_MUL;
         ST_MUL:       state_in = ST_MUL_ACC;
         ST_MUL_ACC:   state_in = last_idx ? ST_ADIV : ST_CDIV;
         ST_ADIV:      state_in = (tot_ff == '0) ? ST_OUT : ST_ADIV_WAIT;
         ST_ADIV_WAIT: if (div_rsp.done) state_in = ST_OUT;
         ST_OUT:       if (!rsp_valid_ff || !rsp_stall)
                          state_in = last_idx ? ST_IDLE : ST_ADIV;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      idx_in   = idx_ff;
      rsum_in  = rsum_ff;
      tot_in   = tot_ff;
      uni_in   = uni_ff;
      count_in = count_ff;
      div_req  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in  = '0;
            rsum_in = '0;
            tot_in  = '0;
            if (accept) count_in = closes ? '0 : slot + CW'(1);
         end
         ST_RSUM: begin
            rsum_in = rsum_ff + 36'(regret_ff[idx_ff]);
            idx_in  = last_idx ? '0 : idx_ff + IW'(1);
         end
         ST_UNI: begin
            div_req.start    = 1'b1;
            div_req.dividend = 64'(ONE_Q16);
            div_req.divisor  = 64'(n_act);
         end
         ST_UNI_WAIT: if (div_rsp.done) uni_in = div_rsp.quotient[PROB_W-1:0];
         ST_CDIV: begin
            div_req.start    = (rsum_ff != '0);
            div_req.dividend = {17'd0, regret_ff[idx_ff], 16'd0};
            div_req.divisor  = 64'(rsum_ff);
         end
         ST_MUL_ACC: begin
            tot_in = tot_ff + 54'(ssum_new[48] ? {SUM_W{1'b1}} : ssum_new[SUM_W-1:0]);
            idx_in = last_idx ? '0 : idx_ff + IW'(1);
         end
         ST_ADIV: begin
            div_req.start    = (tot_ff != '0);
            div_req.dividend = {ssum_ff[idx_ff], 16'd0};
            div_req.divisor  = 64'(tot_ff);
         end
         ST_OUT: if (!rsp_valid_ff || !rsp_stall) idx_in = idx_ff + IW'(1);
         default: ;
      endcase
      if (csr_write) count_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_ff       <= 5'd16;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ACTIONS; i++) begin
            regret_ff[i] <= '0;
            ssum_ff[i]   <= '0;
            strat_ff[i]  <= UNI_RST;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_write) num_ff <= csr_data;
         if (accept) regret_ff[item_idx] <= nr_sat;
         if (state_ff == ST_CDIV && rsum_ff == '0) strat_ff[idx_ff] <= uni_ff;
         if (state_ff == ST_CDIV_WAIT && div_rsp.done)
            strat_ff[idx_ff] <= div_rsp.quotient[PROB_W-1:0];
         if (state_ff == ST_MUL_ACC)
            ssum_ff[idx_ff] <= ssum_new[48] ? '1 : ssum_new[SUM_W-1:0];
         // Hold the result while stalled; load the next one when free.
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) reach_ff[item_idx] <= reach_sat;
      idx_ff  <= idx_in;
      rsum_ff <= rsum_in;
      tot_ff  <= tot_in;
      uni_ff  <= uni_in;
      if (state_ff == ST_MUL) prod_ff <= reach_ff[idx_ff] * strat_ff[idx_ff];
      // Park the average beside the output register so a waiting item stays intact.
      if (state_ff == ST_ADIV_WAIT && div_rsp.done)
         avg_ff <= div_rsp.quotient[PROB_W-1:0];
      if (state_ff == ST_ADIV && tot_ff == '0) avg_ff <= uni_ff;
      if (out_load) begin
         rsp_ff.action_index <= 4'(idx_ff);
         rsp_ff.current_prob <= strat_ff[idx_ff];
         rsp_ff.average_prob <= avg_ff;
         rsp_ff.last         <= last_idx;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !accept) else $error("item taken while busy");
   a_out_only: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> $past(state_ff) == ST_OUT) else $error("stray result");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> count_ff <= CW'(MAX_ACTIONS)) else $error("count range");
`endif
endmodule

### sim/regret_matching_plus_update_test.sv
// Testbench for the regret-matching-plus update block: random items, scoreboard check.
`timescale 1ns / 100ps

module regret_matching_plus_update_test;
   import rmp_pkg::*;

   localparam int MAX_ACT = 16;
   localparam longint REGRET_TOP = 64'h7FFF_FFFF;
   localparam longint SUM_TOP = 64'hFFFF_FFFF_FFFF;
   localparam longint CYCLE_LIMIT = 3_000_000;
   localparam logic [4:0] CFG_NUM_ACTIONS = 5'd0;

   // Scoreboard: keeps its own copy of the block state and queues the expected results.
   class rmp_scoreboard;
      logic [4:0] action_cfg;
      longint unsigned regret_mem[MAX_ACT];
      longint unsigned strat_sum_mem[MAX_ACT];
      longint unsigned strat_mem[MAX_ACT];
      longint unsigned reach_mem[MAX_ACT];
      int open_count;
      rsp_type pending_q[$];
      int err_count;

      function void init();
         action_cfg = 5'd16;
         open_count = 0;
         err_count = 0;
         for (int i = 0; i < MAX_ACT; i++) begin
            regret_mem[i] = 0;
            strat_sum_mem[i] = 0;
            strat_mem[i] = 65536 / 16;
            reach_mem[i] = 0;
         end
      endfunction

      function int action_total();
         if (action_cfg == 0) return 1;
         if (action_cfg > MAX_ACT) return MAX_ACT;
         return action_cfg;
      endfunction

      function void set_actions(logic [4:0] val);
         action_cfg = val;
         open_count = 0;
      endfunction

      // Note one accepted input item; queue the results when it closes a run.
      function void note_item(req_type item);
         int n;
         int idx;
         longint signed upd;
         longint unsigned rsum, ssum, reach, avg, s;
         rsp_type r;
         n = action_total();
         idx = (open_count >= n) ? n - 1 : open_count;
         upd = longint'(regret_mem[idx]) + longint'(item.regret_delta);
         if (upd < 0) upd = 0;
         if (upd > REGRET_TOP) upd = REGRET_TOP;
         regret_mem[idx] = upd;
         reach = (item.reach_prob > 65536) ? 65536 : item.reach_prob;
         reach_mem[idx] = reach;
         if (idx + 1 < n) begin
            open_count = idx + 1;
            return;
         end
         open_count = 0;
         rsum = 0;
         ssum = 0;
         for (int i = 0; i < n; i++) rsum += regret_mem[i];
         for (int i = 0; i < n; i++)
            strat_mem[i] = (rsum != 0) ? (regret_mem[i] * 65536) / rsum : 65536 / n;
         for (int i = 0; i < n; i++) begin
            s = strat_sum_mem[i] + reach_mem[i] * strat_mem[i];
            strat_sum_mem[i] = (s > SUM_TOP) ? SUM_TOP : s;
            ssum += strat_sum_mem[i];
         end
         for (int i = 0; i < n; i++) begin
            avg = (ssum != 0) ? (strat_sum_mem[i] * 65536) / ssum : 65536 / n;
            r.action_index = i[3:0];
            r.current_prob = strat_mem[i][16:0];
            r.average_prob = avg[16:0];
            r.last = (i + 1 == n);
            pending_q.push_back(r);
         end
      endfunction

      // Compare one accepted result with the oldest expectation.
      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_q.size() == 0) begin
            $error("unexpected result: action_index %0d", got.action_index);
            err_count++;
            return;
         end
         want = pending_q.pop_front();
         if (got.action_index !== want.action_index) begin
            $error("action_index: expected %0d, got %0d", want.action_index,
                   got.action_index);
            err_count++;
         end
         if (got.current_prob !== want.current_prob) begin
            $error("current_prob: expected %0d, got %0d", want.current_prob,
                   got.current_prob);
            err_count++;
         end
         if (got.average_prob !== want.average_prob) begin
            $error("average_prob: expected %0d, got %0d", want.average_prob,
                   got.average_prob);
            err_count++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            err_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_write;
   logic [4:0] csr_data;

   rmp_scoreboard board;
   longint cycle_count;
   bit stim_done;

   regret_matching_plus_update #(.MAX_ACTIONS(MAX_ACT)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write(csr_write),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Pick a gap length: often none, often short, sometimes long.
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Drive one item and hold it until the block accepts it.
   task automatic send_item(logic signed [31:0] delta, logic [16:0] reach, bit idle_ok);
      int gap;
      gap = idle_ok ? gap_len() : 0;
      repeat (gap) @(negedge clock);
      req_data.regret_delta = delta;
      req_data.reach_prob = reach;
      req_valid = 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      board.note_item(req_data);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Wait for every expected result, then let the sequencer finish.
   task automatic drain();
      while (board.pending_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Write num_actions while the block is idle.
   task automatic write_actions(logic [4:0] val);
      drain();
      csr_data = val;
      csr_write = 1'b1;
      @(negedge clock);
      csr_write = 1'b0;
      board.set_actions(val);
   endtask

   function automatic logic signed [31:0] rand_delta();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $urandom();
         3, 4: return -$signed(32'($urandom_range(0, 200000)));
         default: return $urandom_range(0, 300000);
      endcase
   endfunction

   function automatic logic [16:0] rand_reach();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 17'h1FFFF;
      if (pick == 1) return 17'd65536;
      if (pick == 2) return 17'($urandom());
      return 17'($urandom_range(0, 65536));
   endfunction

   // Result side: sample at the rising edge, stall at random.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
         @(negedge clock);
         rsp_stall = (stim_done || $urandom_range(0, 99) < 30)
                     ? ($urandom_range(0, 99) < 30) : 1'b0;
         if ($urandom_range(0, 99) < 3) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(5, 40)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // Watchdog.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      int sent;
      logic [4:0] cfg_plan[6];
      board = new();
      board.init();
      stim_done = 1'b0;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_data = CFG_NUM_ACTIONS;
      reset = 1'b1;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed: default 16 actions with field extremes, all regrets zero first.
      for (int i = 0; i < 16; i++)
         send_item((i == 0) ? 32'sh7FFF_FFFF : (i == 1) ? 32'sh8000_0000 :
                   (i < 4) ? 32'sd0 : 32'sd65536,
                   (i == 2) ? 17'h1FFFF : (i == 3) ? 17'd0 : 17'd65536, 1'b0);
      write_actions(5'd1);
      send_item(32'sh8000_0000, 17'd0, 1'b0);
      send_item(32'sh7FFF_FFFF, 17'h10001, 1'b0);
      write_actions(5'd0);
      send_item(32'sd5, 17'd100, 1'b0);
      // Partial run then a write drops it; above-range counts clamp to 16.
      write_actions(5'd3);
      send_item(32'sd1000, 17'd5, 1'b0);
      write_actions(5'd31);
      send_item(-32'sd1, 17'd1, 1'b0);

      // Random phases over several settings.
      cfg_plan = '{5'd2, 5'd16, 5'd0, 5'd5, 5'd17, 5'd1};
      sent = 0;
      for (int ph = 0; ph < 6; ph++) begin
         write_actions(cfg_plan[ph]);
         for (int k = 0; k < 70; k++) begin
            send_item(rand_delta(), rand_reach(), 1'b1);
            sent++;
         end
         // Hold the sender until every result is back.
         if (ph == 2) drain();
      end
      // Drop any open run with a write, then send two full runs of four actions.
      write_actions(5'd4);
      for (int k = 0; k < 8; k++) send_item(rand_delta(), rand_reach(), 1'b1);

      stim_done = 1'b1;
      drain();
      repeat (100) @(negedge clock);
      if (board.err_count == 0 && board.pending_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
